### hdl/resistive_sensor_bipolar_averager_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the resistive sensor averager
// Shared helpers for concurrent checks, clocked on clk_i and idle in reset.
// ----------------------------------------------------------------------------
`ifndef RESISTIVE_SENSOR_BIPOLAR_AVERAGER_ASSERT_SVH
`define RESISTIVE_SENSOR_BIPOLAR_AVERAGER_ASSERT_SVH

// Same-cycle implication.
`define RSBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rsba check failed in %m");

// Next-cycle implication.
`define RSBA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rsba check failed in %m");

`endif

### hdl/rsba_pkg.sv
// ----------------------------------------------------------------------------
// rsba_pkg
// Widths, constants and the sequencer state type of the sensor averager.
// ----------------------------------------------------------------------------
package rsba_pkg;

  localparam int RES_W  = 24;
  localparam int K_W    = 16;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic [K_W-1:0]   K_RESET = 16'd4700;
  localparam logic [RES_W-1:0] RES_MAX = 24'h7F_FFFF;
  localparam logic [RES_W-1:0] RES_MIN = 24'h80_0000;

  // Register index as decoded from paddr[2].
  localparam logic REG_KNOWN_RES = 1'b0;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_RES  = 6'b001000,
    ST_MEAN = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

endpackage

### hdl/rsba_if.sv
// ----------------------------------------------------------------------------
// rsba_in_if / rsba_out_if
// Valid/ready channels of the sensor averager: sample pairs in, results out.
// ----------------------------------------------------------------------------
interface rsba_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] supply_sample;
  logic [SAMPLE_BITS-1:0] sensor_sample;

  modport source (output valid, output supply_sample, output sensor_sample, input ready);
  modport sink   (input valid, input supply_sample, input sensor_sample, output ready);
endinterface

interface rsba_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [rsba_pkg::RES_W-1:0] resistance;
  logic                             zero_sensor;
  logic                             phase_done;
  logic signed [rsba_pkg::RES_W-1:0] phase_average;
  logic                             pair_done;
  logic signed [rsba_pkg::RES_W-1:0] resistance_bias;
  logic signed [rsba_pkg::RES_W-1:0] compensated_resistance;

  modport source (
    output valid, output resistance, output zero_sensor, output phase_done,
    output phase_average, output pair_done, output resistance_bias,
    output compensated_resistance, input ready
  );
  modport sink (
    input valid, input resistance, input zero_sensor, input phase_done,
    input phase_average, input pair_done, input resistance_bias,
    input compensated_resistance, output ready
  );
endinterface

### hdl/resistive_sensor_bipolar_averager.sv
// ----------------------------------------------------------------------------
// resistive_sensor_bipolar_averager
// Datapath: a bit-serial shift-add multiplier and a radix-2 restoring
//   divider (one quotient bit a cycle) share a DW-bit dividend register,
//   where DW = max(16 + SAMPLE_BITS, 25 + clog2(READS_PER_PHASE)) (28 at
//   defaults); an item that ends a phase runs the divider again for the mean.
// Flow: a new sample pair is taken only in idle, once the last item's result
//   is in the output register; a result the sink holds back stalls the
//   sequencer before that hand-over.
// Reset: async active low; clears sums, phase state, handshakes; known
//   resistor returns to 4700 ohms. No clearing pass.
// ----------------------------------------------------------------------------
// Per item: R = K * (supply - sensor) / sensor, truncated toward zero.
// The product is built MSB first into the divider's dividend register, then
// the same register shifts through the restoring divider. At the end of a
// phase the divider is reused to take the mean (sum / READS_PER_PHASE),
// after which bias and compensated values are formed on the second phase.
// ----------------------------------------------------------------------------
`include "resistive_sensor_bipolar_averager_assert.svh"

module resistive_sensor_bipolar_averager #(
  parameter int READS_PER_PHASE = 5,
  parameter int SAMPLE_BITS     = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rsba_in_if.sink                     in_i,
  rsba_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsba_pkg::APB_AW-1:0] paddr,
  input  logic [rsba_pkg::APB_DW-1:0] pwdata,
  output logic [rsba_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int RES_W  = rsba_pkg::RES_W;
  localparam int K_W    = rsba_pkg::K_W;
  localparam int SB     = SAMPLE_BITS;
  localparam int RW     = $clog2(READS_PER_PHASE + 1);
  localparam int DVW    = (SB > RW) ? SB : RW;                   // divisor width
  localparam int SUM_W  = RES_W + 1 + $clog2(READS_PER_PHASE);   // phase sum width
  localparam int MUL_W  = K_W + SB;                              // product width
  localparam int DW     = (MUL_W > SUM_W) ? MUL_W : SUM_W;       // dividend width
  localparam int STEP_W = $clog2(DW);
  localparam int CNT_W  = (READS_PER_PHASE > 1) ? $clog2(READS_PER_PHASE) : 1;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(READS_PER_PHASE - 1);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  rsba_pkg::state_e state_q, state_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic                    mean_q, mean_d;       // divider runs for the mean
  logic signed [SUM_W-1:0] phase_sum_q, phase_sum_d;
  logic [CNT_W-1:0]        item_cnt_q, item_cnt_d;
  logic [RES_W-1:0]        first_q, first_d;
  logic                    second_q, second_d;
  logic [K_W-1:0]          known_res_q;
  logic                    out_valid_q, out_valid_d;

  logic [SB-1:0]    mag_q, mag_d;        // multiplier operand, shifts left
  logic [DVW-1:0]   dsr_q, dsr_d;        // divisor
  logic [DVW-1:0]   rem_q, rem_d;        // partial remainder
  logic [DW-1:0]    dd_q, dd_d;          // product accumulator / dividend / quotient
  logic             neg_q, neg_d;        // sign of the current quotient
  logic             zero_q, zero_d;
  logic [RES_W-1:0] res_q, res_d;
  logic             pdone_q, pdone_d;
  logic [RES_W-1:0] avg_q, avg_d;
  logic             pair_q, pair_d;
  logic [RES_W-1:0] bias_q, bias_d;
  logic [RES_W-1:0] comp_q, comp_d;

  logic [RES_W-1:0] o_res_q, o_avg_q, o_bias_q, o_comp_q;
  logic             o_zero_q, o_pdone_q, o_pair_q;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == rsba_pkg::REG_KNOWN_RES);
  assign prdata = (paddr[2] == rsba_pkg::REG_KNOWN_RES)
                  ? rsba_pkg::APB_DW'(known_res_q) : '0;

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic             in_acc;
  logic             out_free;
  logic             smp_neg;
  logic [SB-1:0]    smp_mag;
  logic [DVW:0]     trial;
  logic [DVW:0]     trial_sub;
  logic             q_bit;
  logic [RES_W-1:0] res_w;
  logic signed [SUM_W-1:0] sum_new;
  logic [SUM_W-1:0] sum_mag;
  logic [RES_W-1:0] avg_w;
  logic [RES_W:0]   bias_wide;
  logic [RES_W:0]   pair_sum;
  logic [RES_W:0]   pair_adj;
  logic [RES_W-1:0] bias_w;

  assign in_i.ready = (state_q == rsba_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign smp_neg = in_i.sensor_sample > in_i.supply_sample;
  assign smp_mag = smp_neg ? (in_i.sensor_sample - in_i.supply_sample)
                           : (in_i.supply_sample - in_i.sensor_sample);

  // One restoring step: bring down the dividend MSB, subtract if it fits.
  assign trial     = {rem_q, dd_q[DW-1]};
  assign trial_sub = trial - {1'b0, dsr_q};
  assign q_bit     = trial >= {1'b0, dsr_q};

  // Finished quotient to resistance: saturate on zero sensor or overflow.
  always_comb begin
    priority if (zero_q) begin
      res_w = rsba_pkg::RES_MAX;
    end else if (neg_q) begin
      res_w = -dd_q[RES_W-1:0];
    end else if (|dd_q[DW-1:RES_W-1]) begin
      res_w = rsba_pkg::RES_MAX;
    end else begin
      res_w = dd_q[RES_W-1:0];
    end
  end

  assign sum_new = phase_sum_q + {{(SUM_W-RES_W){res_w[RES_W-1]}}, res_w};
  assign sum_mag = sum_new[SUM_W-1] ? -sum_new : sum_new;

  assign avg_w     = neg_q ? -dd_q[RES_W-1:0] : dd_q[RES_W-1:0];
  assign bias_wide = {first_q[RES_W-1], first_q} - {avg_w[RES_W-1], avg_w};
  assign pair_sum  = {first_q[RES_W-1], first_q} + {avg_w[RES_W-1], avg_w};
  // Bias toward zero before halving so negative sums truncate correctly.
  assign pair_adj  = pair_sum + (RES_W+1)'(pair_sum[RES_W]);

  always_comb begin
    if (bias_wide[RES_W] != bias_wide[RES_W-1]) begin
      bias_w = bias_wide[RES_W] ? rsba_pkg::RES_MIN : rsba_pkg::RES_MAX;
    end else begin
      bias_w = bias_wide[RES_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    mean_d      = mean_q;
    phase_sum_d = phase_sum_q;
    item_cnt_d  = item_cnt_q;
    first_d     = first_q;
    second_d    = second_q;
    out_valid_d = out_valid_q;
    mag_d       = mag_q;
    dsr_d       = dsr_q;
    rem_d       = rem_q;
    dd_d        = dd_q;
    neg_d       = neg_q;
    zero_d      = zero_q;
    res_d       = res_q;
    pdone_d     = pdone_q;
    avg_d       = avg_q;
    pair_d      = pair_q;
    bias_d      = bias_q;
    comp_d      = comp_q;

    // Drop the result once the sink takes it.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      rsba_pkg::ST_IDLE: begin
        if (in_acc) begin
          mag_d   = smp_mag;
          dsr_d   = DVW'(in_i.sensor_sample);
          neg_d   = smp_neg;
          zero_d  = (in_i.sensor_sample == '0);
          dd_d    = '0;
          mean_d  = 1'b0;
          step_d  = STEP_W'(SB - 1);
          state_d = rsba_pkg::ST_MUL;
        end
      end
      rsba_pkg::ST_MUL: begin
        // Shift-add, one multiplier bit a cycle, MSB first.
        dd_d  = {dd_q[DW-2:0], 1'b0} + (mag_q[SB-1] ? DW'(known_res_q) : '0);
        mag_d = {mag_q[SB-2:0], 1'b0};
        if (step_q == '0) begin
          rem_d   = '0;
          step_d  = STEP_W'(DW - 1);
          state_d = rsba_pkg::ST_DIV;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      rsba_pkg::ST_DIV: begin
        rem_d = q_bit ? trial_sub[DVW-1:0] : trial[DVW-1:0];
        dd_d  = {dd_q[DW-2:0], q_bit};
        if (step_q == '0) begin
          state_d = mean_q ? rsba_pkg::ST_MEAN : rsba_pkg::ST_RES;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      rsba_pkg::ST_RES: begin
        res_d = res_w;
        if (item_cnt_q == CNT_LAST) begin
          // Phase ends: run the divider again on the phase sum.
          phase_sum_d = '0;
          item_cnt_d  = '0;
          neg_d       = sum_new[SUM_W-1];
          dd_d        = DW'(sum_mag);
          dsr_d       = DVW'(READS_PER_PHASE);
          rem_d       = '0;
          mean_d      = 1'b1;
          step_d      = STEP_W'(DW - 1);
          state_d     = rsba_pkg::ST_DIV;
        end else begin
          phase_sum_d = sum_new;
          item_cnt_d  = item_cnt_q + 1'b1;
          pdone_d     = 1'b0;
          avg_d       = '0;
          pair_d      = 1'b0;
          bias_d      = '0;
          comp_d      = '0;
          state_d     = rsba_pkg::ST_OUT;
        end
      end
      rsba_pkg::ST_MEAN: begin
        pdone_d = 1'b1;
        avg_d   = avg_w;
        if (second_q) begin
          pair_d   = 1'b1;
          bias_d   = bias_w;
          comp_d   = pair_adj[RES_W:1];
          second_d = 1'b0;
        end else begin
          pair_d   = 1'b0;
          bias_d   = '0;
          comp_d   = '0;
          first_d  = avg_w;
          second_d = 1'b1;
        end
        state_d = rsba_pkg::ST_OUT;
      end
      rsba_pkg::ST_OUT: begin
        // Hold until the output register is free.
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = rsba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rsba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsba_pkg::ST_IDLE;
      step_q      <= '0;
      mean_q      <= 1'b0;
      phase_sum_q <= '0;
      item_cnt_q  <= '0;
      first_q     <= '0;
      second_q    <= 1'b0;
      known_res_q <= rsba_pkg::K_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      mean_q      <= mean_d;
      phase_sum_q <= phase_sum_d;
      item_cnt_q  <= item_cnt_d;
      first_q     <= first_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        known_res_q <= pwdata[K_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    dsr_q   <= dsr_d;
    rem_q   <= rem_d;
    dd_q    <= dd_d;
    neg_q   <= neg_d;
    zero_q  <= zero_d;
    res_q   <= res_d;
    pdone_q <= pdone_d;
    avg_q   <= avg_d;
    pair_q  <= pair_d;
    bias_q  <= bias_d;
    comp_q  <= comp_d;
    if (state_q == rsba_pkg::ST_OUT && out_free) begin
      o_res_q   <= res_q;
      o_zero_q  <= zero_q;
      o_pdone_q <= pdone_q;
      o_avg_q   <= avg_q;
      o_pair_q  <= pair_q;
      o_bias_q  <= bias_q;
      o_comp_q  <= comp_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output channel
  // --------------------------------------------------------------------------
  assign out_o.valid                  = out_valid_q;
  assign out_o.resistance             = o_res_q;
  assign out_o.zero_sensor            = o_zero_q;
  assign out_o.phase_done             = o_pdone_q;
  assign out_o.phase_average          = o_avg_q;
  assign out_o.pair_done              = o_pair_q;
  assign out_o.resistance_bias        = o_bias_q;
  assign out_o.compensated_resistance = o_comp_q;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `RSBA_ASSERT_IMP(a_cnt_range, 1'b1, item_cnt_q <= CNT_LAST)
  `RSBA_ASSERT_NXT(a_acc_starts_mul, in_acc, state_q == rsba_pkg::ST_MUL)
  `RSBA_ASSERT_IMP(a_pair_in_phase, out_valid_q && o_pair_q, o_pdone_q)
  `RSBA_ASSERT_IMP(a_zero_sat, out_valid_q && o_zero_q, o_res_q == rsba_pkg::RES_MAX)

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives sample pairs into the bipolar resistive sensor averager over its
// valid/ready channels, writes the known resistor over APB between runs, and
// compares every result item against a cycle-free model of the averaging.
// ----------------------------------------------------------------------------
module testbench;

  localparam int     READS_PER_PHASE = 5;
  localparam int     SAMPLE_BITS     = 10;
  localparam int     RES_W           = rsba_pkg::RES_W;
  localparam int     K_W             = rsba_pkg::K_W;
  localparam int     APB_AW          = rsba_pkg::APB_AW;
  localparam int     APB_DW          = rsba_pkg::APB_DW;
  localparam longint OHMS_MAX        = 64'sd8388607;
  localparam longint OHMS_MIN        = -64'sd8388608;
  localparam int     RANDOM_ITEMS    = 700;
  localparam int     QUIET_ITEMS     = 80;
  // Longest correct silence is a phase-ending item plus a sender gap and a
  // receiver stall; take it many times over.
  localparam int     SILENCE_LIMIT   = 2000;
  localparam int     DRAIN_CYCLES    = 120;
  localparam int     PRINT_LIMIT     = 100;

  localparam logic [APB_AW-1:0] ADDR_KNOWN_RES = {rsba_pkg::REG_KNOWN_RES, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_SPARE     = {~rsba_pkg::REG_KNOWN_RES, 2'b00};

  // Sample pattern used for a whole phase of the random part.
  typedef enum logic [1:0] {
    PH_MIXED,
    PH_ZERO_SENSOR,
    PH_NEGATIVE,
    PH_LARGE
  } phase_kind_e;

  typedef struct packed {
    logic signed [RES_W-1:0] resistance;
    logic                    zero_sensor;
    logic                    phase_done;
    logic signed [RES_W-1:0] phase_average;
    logic                    pair_done;
    logic signed [RES_W-1:0] resistance_bias;
    logic signed [RES_W-1:0] compensated_resistance;
  } reading_t;

  // Tracks the divider resistor, the running phase sum and the first-phase
  // mean; holds the readings the block still owes us, oldest first.
  class sensor_mean_scoreboard;
    bit [K_W-1:0]   known_ohms;
    longint         phase_sum;
    int unsigned    phase_items;
    longint         first_mean;
    bit             in_second_phase;
    reading_t       owed_readings[$];
    int             mismatch_count;

    function new();
      known_ohms      = rsba_pkg::K_RESET;
      phase_sum       = 0;
      phase_items     = 0;
      first_mean      = 0;
      in_second_phase = 1'b0;
      mismatch_count  = 0;
    endfunction

    static function longint clip24(longint v);
      if (v > OHMS_MAX) return OHMS_MAX;
      if (v < OHMS_MIN) return OHMS_MIN;
      return v;
    endfunction

    function void set_register(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
      if (addr[APB_AW-1] == rsba_pkg::REG_KNOWN_RES) known_ohms = data[K_W-1:0];
    endfunction

    function int pending();
      return owed_readings.size();
    endfunction

    // Note one accepted sample pair and queue the reading it must produce.
    function void note_samples(logic [SAMPLE_BITS-1:0] supply,
                               logic [SAMPLE_BITS-1:0] sensor);
      reading_t r;
      longint   ohms;
      longint   mean;
      longint   bias;
      longint   comp;
      r = '0;
      if (sensor == '0) begin
        ohms          = OHMS_MAX;
        r.zero_sensor = 1'b1;
      end else begin
        ohms = clip24((longint'(known_ohms) * (longint'(supply) - longint'(sensor)))
                      / longint'(sensor));
      end
      r.resistance = ohms[RES_W-1:0];
      phase_sum += ohms;
      phase_items++;
      if (phase_items >= READS_PER_PHASE) begin
        mean            = phase_sum / READS_PER_PHASE;
        r.phase_done    = 1'b1;
        r.phase_average = mean[RES_W-1:0];
        phase_sum       = 0;
        phase_items     = 0;
        if (in_second_phase) begin
          bias                     = clip24(first_mean - mean);
          comp                     = (first_mean + mean) / 2;
          r.pair_done              = 1'b1;
          r.resistance_bias        = bias[RES_W-1:0];
          r.compensated_resistance = comp[RES_W-1:0];
          in_second_phase          = 1'b0;
        end else begin
          first_mean      = mean;
          in_second_phase = 1'b1;
        end
      end
      owed_readings.push_back(r);
    endfunction

    task report_mismatch(string what);
      if (mismatch_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
    endtask

    task check_reading(reading_t got);
      reading_t want;
      if (owed_readings.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed, resistance %0d",
                                  got.resistance));
        return;
      end
      want = owed_readings.pop_front();
      if (got.resistance !== want.resistance)
        report_mismatch($sformatf("resistance %0d, want %0d",
                                  got.resistance, want.resistance));
      if (got.zero_sensor !== want.zero_sensor)
        report_mismatch($sformatf("zero_sensor %b, want %b",
                                  got.zero_sensor, want.zero_sensor));
      if (got.phase_done !== want.phase_done)
        report_mismatch($sformatf("phase_done %b, want %b",
                                  got.phase_done, want.phase_done));
      if (got.phase_average !== want.phase_average)
        report_mismatch($sformatf("phase_average %0d, want %0d",
                                  got.phase_average, want.phase_average));
      if (got.pair_done !== want.pair_done)
        report_mismatch($sformatf("pair_done %b, want %b",
                                  got.pair_done, want.pair_done));
      if (got.resistance_bias !== want.resistance_bias)
        report_mismatch($sformatf("resistance_bias %0d, want %0d",
                                  got.resistance_bias, want.resistance_bias));
      if (got.compensated_resistance !== want.compensated_resistance)
        report_mismatch($sformatf("compensated_resistance %0d, want %0d",
                                  got.compensated_resistance,
                                  want.compensated_resistance));
    endtask

    task check_register(logic [APB_DW-1:0] got);
      if (got[K_W-1:0] !== known_ohms)
        report_mismatch($sformatf("known resistor reads %0d, want %0d",
                                  got[K_W-1:0], known_ohms));
    endtask

    task check_leftover();
      if (owed_readings.size() != 0)
        report_mismatch($sformatf("%0d readings never arrived", owed_readings.size()));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  bit                 idling_on;
  int                 stall_left;
  int                 silent_cycles;
  phase_kind_e        first_kind;
  phase_kind_e        second_kind;

  sensor_mean_scoreboard tracker = new();

  rsba_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  rsba_out_if                             out_ch ();

  resistive_sensor_bipolar_averager #(
    .READS_PER_PHASE(READS_PER_PHASE),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) i_dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: hold ready low for random bursts while idling is on; one
  // assignment per falling edge keeps the handshake race free.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      out_ch.ready = 1'b0;
      stall_left   = $urandom_range(0, 8);
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Sample every accepted result item at the rising edge and check it.
  always @(posedge clk) begin
    reading_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.resistance             = out_ch.resistance;
      got.zero_sensor            = out_ch.zero_sensor;
      got.phase_done             = out_ch.phase_done;
      got.phase_average          = out_ch.phase_average;
      got.pair_done              = out_ch.pair_done;
      got.resistance_bias        = out_ch.resistance_bias;
      got.compensated_resistance = out_ch.compensated_resistance;
      tracker.check_reading(got);
    end
  end

  // Watchdog: any handshake or register access counts as progress.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      silent_cycles = 0;
    end else begin
      silent_cycles++;
    end
    if (silent_cycles >= SILENCE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Present one sample pair, maybe after an idle burst, and hold it until
  // the block takes it; log it with the model at the accepting edge.
  task automatic drive_samples(logic [SAMPLE_BITS-1:0] supply,
                               logic [SAMPLE_BITS-1:0] sensor);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.supply_sample = supply;
    in_ch.sensor_sample = sensor;
    in_ch.valid         = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_samples(supply, sensor);
  endtask

  // Drop valid and wait until every owed reading is back; the block is then
  // idle, since each item yields exactly one result.
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.set_register(addr, data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apb_read(logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Write the divider resistor with junk in the upper bits, then read it
  // back. Optionally poke the unmapped register first, which must not stick.
  task automatic load_known_ohms(logic [K_W-1:0] ohms, bit poke_spare);
    logic [APB_DW-1:0] rd;
    settle();
    if (poke_spare) apb_write(ADDR_SPARE, $urandom);
    apb_write(ADDR_KNOWN_RES, {16'($urandom), ohms});
    apb_read(ADDR_KNOWN_RES, rd);
    tracker.check_register(rd);
  endtask

  function automatic logic [K_W-1:0] pick_known_ohms();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return rsba_pkg::K_RESET;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // Choose the sample pattern of both phases of a pair, so that the
  // saturating bias and lopsided means come up often.
  function automatic void pick_pair_kinds();
    case ($urandom_range(0, 9))
      6: begin first_kind = PH_ZERO_SENSOR; second_kind = PH_NEGATIVE;    end
      7: begin first_kind = PH_NEGATIVE;    second_kind = PH_ZERO_SENSOR; end
      8: begin first_kind = PH_LARGE;       second_kind = PH_LARGE;       end
      9: begin first_kind = PH_ZERO_SENSOR; second_kind = PH_LARGE;       end
      default: begin first_kind = PH_MIXED; second_kind = PH_MIXED;       end
    endcase
  endfunction

  task automatic random_item();
    phase_kind_e            kind;
    logic [SAMPLE_BITS-1:0] supply;
    logic [SAMPLE_BITS-1:0] sensor;
    if (tracker.phase_items == 0 && !tracker.in_second_phase) pick_pair_kinds();
    kind   = tracker.in_second_phase ? second_kind : first_kind;
    supply = SAMPLE_BITS'($urandom);
    sensor = SAMPLE_BITS'($urandom);
    case (kind)
      PH_ZERO_SENSOR: sensor = '0;
      PH_NEGATIVE: begin
        supply = SAMPLE_BITS'($urandom_range(0, 3));
        sensor = SAMPLE_BITS'($urandom_range(1000, 1023));
      end
      PH_LARGE: begin
        supply = SAMPLE_BITS'($urandom_range(900, 1023));
        sensor = SAMPLE_BITS'($urandom_range(1, 4));
      end
      default: begin
        case ($urandom_range(0, 9))
          0: sensor = '0;
          1: begin supply = '0; sensor = '1; end
          2: begin supply = '1; sensor = 10'd1; end
          default: ;
        endcase
      end
    endcase
    drive_samples(supply, sensor);
  endtask

  initial begin
    logic [APB_DW-1:0] rd;
    int                sent;
    int                run_len;

    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.supply_sample = '0;
    in_ch.sensor_sample = '0;
    out_ch.ready        = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    idling_on           = 1'b1;
    stall_left          = 0;
    silent_cycles       = 0;
    first_kind          = PH_MIXED;
    second_kind         = PH_MIXED;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // The resistor must come out of reset at its default.
    apb_read(ADDR_KNOWN_RES, rd);
    tracker.check_register(rd);

    // First phase at the default resistor: equal samples, most negative
    // reading, largest in-range reading, zero sensor, a quotient of exactly minus one half.
    drive_samples(10'd1023, 10'd1023);
    drive_samples(10'd0,    10'd1023);
    drive_samples(10'd1023, 10'd1);
    drive_samples(10'd0,    10'd0);
    drive_samples(10'h155,  10'h2AA);

    // Second phase at the largest resistor: quotient above the 24 bit range,
    // more zero sensors, alternating bit patterns.
    load_known_ohms(16'hFFFF, 1'b1);
    drive_samples(10'd1023, 10'd1);
    drive_samples(10'd1023, 10'd0);
    drive_samples(10'h2AA,  10'h155);
    drive_samples(10'd1,    10'd1);
    drive_samples(10'h3FF,  10'h200);

    // Next pair: a negative first mean against a saturated second mean
    // drives the bias below the 24 bit range.
    repeat (5) drive_samples(10'd0, 10'd1023);
    drive_samples(10'd0,    10'd0);
    drive_samples(10'd1023, 10'd0);
    drive_samples(10'h155,  10'd0);
    drive_samples(10'h2AA,  10'd0);
    drive_samples(10'd1,    10'd0);

    // Zero resistor: everything reads 0 but the zero sensor saturation.
    load_known_ohms('0, 1'b0);
    drive_samples(10'd1023, 10'd3);
    drive_samples(10'd0,    10'd0);

    // Random part in runs, each at a fresh resistor value. Runs do not line
    // up with phases, so writes land mid phase too. Drop idling at the end.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - QUIET_ITEMS) idling_on = 1'b0;
      load_known_ohms(pick_known_ohms(), $urandom_range(0, 3) == 0);
      run_len = $urandom_range(15, 90);
      repeat (run_len) begin
        if (sent < RANDOM_ITEMS) begin
          random_item();
          sent++;
        end
      end
    end

    // Wait for the tail, then give stray results a chance to show up.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    tracker.check_leftover();
    if (tracker.mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/rsba_pkg.sv
hdl/rsba_if.sv
hdl/resistive_sensor_bipolar_averager.sv
sim/testbench.sv
